/* src/gpi_pkg.sv */
// ----------------------------------------------------------------------------
// gpi_pkg: gesture pointer interpolator shared definitions
// Beat structures, opcode/status codes, register indexes and widths.
// ----------------------------------------------------------------------------
package gpi_pkg;

    localparam int COORD_BITS = 12;
    localparam int DUR_BITS   = 11;
    localparam int PROD_BITS  = COORD_BITS + DUR_BITS;
    localparam int CNT_BITS   = $clog2((COORD_BITS > DUR_BITS) ? COORD_BITS : DUR_BITS);
    localparam int CFG_BITS   = 13;
    localparam int PT_BITS    = 12;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_TAP   = 2'd1;
    localparam logic [1:0] OP_SWIPE = 2'd2;
    localparam logic [1:0] OP_OTHER = 2'd3;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_BUSY    = 2'd1;
    localparam logic [1:0] STS_INVALID = 2'd2;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] SCREEN_RESET = 13'd480;
    localparam logic signed [15:0]  TAP_MS = 16'sd100;
    localparam logic signed [15:0]  MIN_MS = 16'sd20;
    localparam logic signed [15:0]  MAX_MS = 16'sd2000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        now_ms;
        logic [31:0]        request_id;
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
        logic signed [15:0] span_ms;
    } gpi_in_t;

    typedef struct packed {
        logic               kind;
        logic [PT_BITS-1:0] point_x;
        logic [PT_BITS-1:0] point_y;
        logic               pressed;
        logic [31:0]        reply_id;
        logic [1:0]         status;
        logic               last;
    } gpi_out_t;

    // up to two result beats written into the output queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        gpi_out_t   first;
        gpi_out_t   second;
    } gpi_push_t;

endpackage

/* src/gesture_pointer_interpolator_top.sv */
// ----------------------------------------------------------------------------
// gesture_pointer_interpolator_top: touch gesture synthesizer
// Commands and gesture-ending ticks write their beats into the result queue as
//   they are accepted; a mid-gesture tick runs 11 multiply steps and 12 divide
//   steps in the serial lanes, plus fixup, queue write and output.
// Throughput: one item per cycle except while a mid-gesture tick is computed
//   (s_ready is held low); three or more queued result beats stall the input.
// Reset: synchronous active-low aresetn; screen size 480x480, no gesture.
// ----------------------------------------------------------------------------
module gesture_pointer_interpolator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gpi_pkg::gpi_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gpi_pkg::gpi_out_t                 m_data,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [gpi_pkg::CFG_BITS-1:0]      cfg_wdata
);

    localparam int CB = gpi_pkg::COORD_BITS;
    localparam int EW = gpi_pkg::DUR_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic                         state_reg, state_next;
    logic [gpi_pkg::CFG_BITS-1:0] width_reg, height_reg;
    logic                         active_reg, active_next;
    logic                         pressed_reg, pressed_next;
    logic [CB-1:0]                begin_x_reg, begin_y_reg, finish_x_reg, finish_y_reg;
    logic [EW-1:0]                length_reg;
    logic [31:0]                  begin_time_reg, pending_id_reg;

    logic               accept, is_tick, launch, capture;
    logic [31:0]        elapsed;
    logic               finish;
    logic signed [15:0] end_x, end_y, dur;
    logic               args_ok;
    logic               room, done_x, done_y;
    logic [CB-1:0]      lane_x, lane_y;
    gpi_pkg::gpi_push_t push;
    gpi_pkg::gpi_out_t  blank;

    function automatic logic coord_ok(input logic signed [15:0] c,
                                      input logic [gpi_pkg::CFG_BITS-1:0] lim);
        logic [15:0] cu;
        cu = c;
        coord_ok = !cu[15] && ((cu >> CB) == 16'd0) && ({3'b0, lim} > cu);
    endfunction

    assign accept  = s_valid && s_ready;
    assign is_tick = (s_data.opcode == gpi_pkg::OP_TICK);
    assign elapsed = s_data.now_ms - begin_time_reg;
    assign finish  = (elapsed >= {{(32-EW){1'b0}}, length_reg});
    assign launch  = accept && is_tick && active_reg && !finish;
    assign s_ready = (state_reg == ST_IDLE) && room;

    always_comb begin
        if (s_data.opcode == gpi_pkg::OP_TAP) begin
            end_x = s_data.from_x;
            end_y = s_data.from_y;
            dur   = gpi_pkg::TAP_MS;
        end else begin
            end_x = s_data.to_x;
            end_y = s_data.to_y;
            dur   = s_data.span_ms;
        end
        args_ok = coord_ok(s_data.from_x, width_reg) && coord_ok(s_data.from_y, height_reg)
               && coord_ok(end_x, width_reg) && coord_ok(end_y, height_reg)
               && (dur >= gpi_pkg::MIN_MS) && (dur <= gpi_pkg::MAX_MS);
    end

    // decide what each beat produces and how the gesture state moves
    always_comb begin
        blank        = '0;
        push.count   = 2'd0;
        push.first   = blank;
        push.second  = blank;
        state_next   = state_reg;
        active_next  = active_reg;
        pressed_next = pressed_reg;
        capture      = 1'b0;
        if (state_reg == ST_CALC) begin
            if (done_x && done_y) begin
                state_next           = ST_IDLE;
                push.count           = 2'd1;
                push.first.kind      = gpi_pkg::KIND_POINT;
                push.first.point_x   = gpi_pkg::PT_BITS'(lane_x);
                push.first.point_y   = gpi_pkg::PT_BITS'(lane_y);
                push.first.pressed   = pressed_reg;
                push.first.last      = 1'b1;
            end
        end else if (accept) begin
            priority if (is_tick) begin
                if (active_reg && finish) begin
                    // release at the end point, then close the command
                    active_next           = 1'b0;
                    pressed_next          = 1'b0;
                    push.count            = 2'd2;
                    push.first.kind       = gpi_pkg::KIND_POINT;
                    push.first.point_x    = gpi_pkg::PT_BITS'(finish_x_reg);
                    push.first.point_y    = gpi_pkg::PT_BITS'(finish_y_reg);
                    push.second.kind      = gpi_pkg::KIND_REPLY;
                    push.second.reply_id  = pending_id_reg;
                    push.second.status    = gpi_pkg::STS_OK;
                    push.second.last      = 1'b1;
                end else if (active_reg) begin
                    state_next = ST_CALC;
                end
            end else if (active_reg) begin
                push.count          = 2'd1;
                push.first.kind     = gpi_pkg::KIND_REPLY;
                push.first.reply_id = s_data.request_id;
                push.first.status   = gpi_pkg::STS_BUSY;
                push.first.last     = 1'b1;
            end else if (s_data.opcode == gpi_pkg::OP_OTHER || !args_ok) begin
                push.count          = 2'd1;
                push.first.kind     = gpi_pkg::KIND_REPLY;
                push.first.reply_id = s_data.request_id;
                push.first.status   = gpi_pkg::STS_INVALID;
                push.first.last     = 1'b1;
            end else begin
                capture            = 1'b1;
                active_next        = 1'b1;
                pressed_next       = 1'b1;
                push.count         = 2'd1;
                push.first.kind    = gpi_pkg::KIND_POINT;
                push.first.point_x = gpi_pkg::PT_BITS'(s_data.from_x[CB-1:0]);
                push.first.point_y = gpi_pkg::PT_BITS'(s_data.from_y[CB-1:0]);
                push.first.pressed = 1'b1;
                push.first.last    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            width_reg      <= gpi_pkg::SCREEN_RESET;
            height_reg     <= gpi_pkg::SCREEN_RESET;
            active_reg     <= 1'b0;
            pressed_reg    <= 1'b0;
            begin_x_reg    <= '0;
            begin_y_reg    <= '0;
            finish_x_reg   <= '0;
            finish_y_reg   <= '0;
            length_reg     <= '0;
            begin_time_reg <= '0;
            pending_id_reg <= '0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            pressed_reg <= pressed_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    gpi_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                    gpi_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (capture) begin
                begin_x_reg    <= s_data.from_x[CB-1:0];
                begin_y_reg    <= s_data.from_y[CB-1:0];
                finish_x_reg   <= end_x[CB-1:0];
                finish_y_reg   <= end_y[CB-1:0];
                length_reg     <= dur[EW-1:0];
                begin_time_reg <= s_data.now_ms;
                pending_id_reg <= s_data.request_id;
            end
        end
    end

    gpi_lane u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (launch),
        .base    (begin_x_reg),
        .target  (finish_x_reg),
        .elapsed (elapsed[EW-1:0]),
        .span    (length_reg),
        .done    (done_x),
        .point   (lane_x)
    );

    gpi_lane u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (launch),
        .base    (begin_y_reg),
        .target  (finish_y_reg),
        .elapsed (elapsed[EW-1:0]),
        .span    (length_reg),
        .done    (done_y),
        .point   (lane_y)
    );

    gpi_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* src/gpi_lane.sv */
// ----------------------------------------------------------------------------
// gpi_lane: one coordinate of the interpolation
// Bit-serial shift-add multiply of |end-start| by elapsed time, then a
// restoring divide by the gesture length one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gpi_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [gpi_pkg::COORD_BITS-1:0]        base,
    input  logic [gpi_pkg::COORD_BITS-1:0]        target,
    input  logic [gpi_pkg::DUR_BITS-1:0]          elapsed,
    input  logic [gpi_pkg::DUR_BITS-1:0]          span,
    output logic                                  done,
    output logic [gpi_pkg::COORD_BITS-1:0]        point
);

    localparam int CB = gpi_pkg::COORD_BITS;
    localparam int EW = gpi_pkg::DUR_BITS;
    localparam int PW = gpi_pkg::PROD_BITS;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIX  = 2'd3;

    logic [1:0]                   phase_reg, phase_next;
    logic                         done_reg, done_next;
    logic [gpi_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]                prod_reg, prod_next;
    logic [CB-1:0]                base_reg, mag_reg, point_reg;
    logic [EW-1:0]                span_reg;
    logic                         neg_reg;

    logic [CB:0]   diff;
    logic          diff_neg;
    logic [CB-1:0] diff_mag;
    logic [CB:0]   mul_sum;
    logic [EW:0]   div_trial;
    logic          div_ge;
    logic [EW:0]   div_rem;

    always_comb begin
        diff     = {1'b0, target} - {1'b0, base};
        diff_neg = diff[CB];
        diff_mag = diff_neg ? CB'(-diff) : diff[CB-1:0];
        mul_sum  = {1'b0, prod_reg[PW-1:EW]} + (prod_reg[0] ? {1'b0, mag_reg} : '0);
        div_trial = {prod_reg[PW-1:CB], prod_reg[CB-1]};
        div_ge    = (div_trial >= {1'b0, span_reg});
        div_rem   = div_ge ? (div_trial - {1'b0, span_reg}) : div_trial;
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    phase_next = PH_MUL;
                    cnt_next   = '0;
                    prod_next  = {{CB{1'b0}}, elapsed};
                end
            end
            PH_MUL: begin
                // add the multiplicand under the low bit, shift right
                prod_next = {mul_sum, prod_reg[EW-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == gpi_pkg::CNT_BITS'(EW - 1)) begin
                    phase_next = PH_DIV;
                    cnt_next   = '0;
                end
            end
            PH_DIV: begin
                // remainder sits in the top bits, quotient shifts in at the bottom
                prod_next = {div_rem[EW-1:0], prod_reg[CB-2:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == gpi_pkg::CNT_BITS'(CB - 1)) begin
                    phase_next = PH_FIX;
                end
            end
            PH_FIX: begin
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (phase_reg == PH_IDLE && start) begin
            base_reg <= base;
            neg_reg  <= diff_neg;
            mag_reg  <= diff_mag;
            span_reg <= span;
        end
        if (phase_reg == PH_FIX) begin
            point_reg <= neg_reg ? (base_reg - prod_reg[CB-1:0])
                                 : (base_reg + prod_reg[CB-1:0]);
        end
    end

    assign done  = done_reg;
    assign point = point_reg;

endmodule

/* src/gpi_outq.sv */
// ----------------------------------------------------------------------------
// gpi_outq: result beat queue
// Four-entry queue that takes up to two beats per cycle and drives m_ side.
// ----------------------------------------------------------------------------
module gpi_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  gpi_pkg::gpi_push_t push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output gpi_pkg::gpi_out_t m_data
);

    gpi_pkg::gpi_out_t slot_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] wr_ptr_plus;

    assign pop         = m_valid && m_ready;
    assign wr_ptr_plus = wr_ptr_reg + 2'd1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            slot_reg[wr_ptr_plus] <= push.second;
        end
    end

    assign room    = (count_reg <= 3'd2);
    assign m_valid = (count_reg != 3'd0);
    assign m_data  = slot_reg[rd_ptr_reg];

endmodule

/* sim/gpi_gesture_monitor.sv */
// ----------------------------------------------------------------------------
// gpi_gesture_monitor: result checker for the gesture pointer interpolator
// Watches the command, result and register ports, keeps its own copy of the
// gesture state, predicts the result beats of every accepted command or tick
// and compares them in order with the beats the block hands out.
// ----------------------------------------------------------------------------
module gpi_gesture_monitor
    import gpi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  gpi_in_t             s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  gpi_out_t            m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    output int                  mismatches,
    output int                  outstanding,
    output int                  beats_checked
);

    logic [CFG_BITS-1:0] screen_w;
    logic [CFG_BITS-1:0] screen_h;
    logic                g_active;
    logic                g_pressed;
    logic [PT_BITS-1:0]  g_from_x;
    logic [PT_BITS-1:0]  g_from_y;
    logic [PT_BITS-1:0]  g_to_x;
    logic [PT_BITS-1:0]  g_to_y;
    logic [DUR_BITS-1:0] g_len;
    logic [31:0]         g_start_ms;
    logic [31:0]         g_id;
    gpi_out_t            pending_reports[$];

    initial begin
        mismatches    = 0;
        outstanding   = 0;
        beats_checked = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] result beat %0d: %s got 0x%0h, want 0x%0h",
                         $time, beats_checked, what, got, want);
        end
    endtask

    function automatic bit on_screen(input int c, input logic [CFG_BITS-1:0] lim);
        int cap;
        cap = int'(lim);
        // registers beyond the coordinate range saturate
        if (cap > (1 << COORD_BITS))
            cap = 1 << COORD_BITS;
        return (c >= 0) && (c < cap);
    endfunction

    // linear position between two points, division truncates toward zero
    function automatic logic [PT_BITS-1:0] blend(input logic [PT_BITS-1:0] a,
                                                 input logic [PT_BITS-1:0] b,
                                                 input logic [31:0] elapsed,
                                                 input logic [DUR_BITS-1:0] len);
        int d;
        d = int'(b) - int'(a);
        return PT_BITS'(int'(a) + d * int'(elapsed) / int'(len));
    endfunction

    function automatic gpi_out_t pointer_beat(input logic [PT_BITS-1:0] x,
                                              input logic [PT_BITS-1:0] y,
                                              input logic pr, input logic fin);
        gpi_out_t b;
        b         = '0;
        b.kind    = KIND_POINT;
        b.point_x = x;
        b.point_y = y;
        b.pressed = pr;
        b.last    = fin;
        return b;
    endfunction

    function automatic gpi_out_t reply_beat(input logic [31:0] id, input logic [1:0] st);
        gpi_out_t b;
        b          = '0;
        b.kind     = KIND_REPLY;
        b.reply_id = id;
        b.status   = st;
        b.last     = 1'b1;
        return b;
    endfunction

    task automatic advance_gesture(input gpi_in_t cmd);
        logic [31:0]        elapsed;
        logic [PT_BITS-1:0] px;
        logic [PT_BITS-1:0] py;
        int                 fx;
        int                 fy;
        int                 tx;
        int                 ty;
        int                 span;
        begin
            if (cmd.opcode == OP_TICK) begin
                if (!g_active)
                    return;
                // a now_ms value behind the start wraps to a huge elapsed time
                elapsed = cmd.now_ms - g_start_ms;
                if (g_len == '0 || elapsed >= 32'(g_len))
                    elapsed = 32'(g_len);
                if (g_len == '0) begin
                    px = g_to_x;
                    py = g_to_y;
                end else begin
                    px = blend(g_from_x, g_to_x, elapsed, g_len);
                    py = blend(g_from_y, g_to_y, elapsed, g_len);
                end
                if (elapsed == 32'(g_len)) begin
                    g_active  = 1'b0;
                    g_pressed = 1'b0;
                    pending_reports.push_back(pointer_beat(px, py, 1'b0, 1'b0));
                    pending_reports.push_back(reply_beat(g_id, STS_OK));
                end else begin
                    pending_reports.push_back(pointer_beat(px, py, g_pressed, 1'b1));
                end
            end else if (g_active) begin
                pending_reports.push_back(reply_beat(cmd.request_id, STS_BUSY));
            end else if (cmd.opcode == OP_OTHER) begin
                pending_reports.push_back(reply_beat(cmd.request_id, STS_INVALID));
            end else begin
                fx = $signed(cmd.from_x);
                fy = $signed(cmd.from_y);
                if (cmd.opcode == OP_TAP) begin
                    tx   = fx;
                    ty   = fy;
                    span = TAP_MS;
                end else begin
                    tx   = $signed(cmd.to_x);
                    ty   = $signed(cmd.to_y);
                    span = $signed(cmd.span_ms);
                end
                if (!on_screen(fx, screen_w) || !on_screen(fy, screen_h) ||
                    !on_screen(tx, screen_w) || !on_screen(ty, screen_h) ||
                    span < MIN_MS || span > MAX_MS) begin
                    pending_reports.push_back(reply_beat(cmd.request_id, STS_INVALID));
                end else begin
                    g_from_x   = PT_BITS'(fx);
                    g_from_y   = PT_BITS'(fy);
                    g_to_x     = PT_BITS'(tx);
                    g_to_y     = PT_BITS'(ty);
                    g_len      = DUR_BITS'(span);
                    g_start_ms = cmd.now_ms;
                    g_id       = cmd.request_id;
                    g_pressed  = 1'b1;
                    g_active   = 1'b1;
                    pending_reports.push_back(pointer_beat(g_from_x, g_from_y, 1'b1, 1'b1));
                end
            end
        end
    endtask

    task automatic compare_beat(input gpi_out_t got);
        gpi_out_t want;
        begin
            if (pending_reports.size() == 0) begin
                report_mismatch("beat with nothing awaited, reply_id", got.reply_id, '0);
                return;
            end
            want = pending_reports.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.point_x !== want.point_x)
                report_mismatch("point_x", 32'(got.point_x), 32'(want.point_x));
            if (got.point_y !== want.point_y)
                report_mismatch("point_y", 32'(got.point_y), 32'(want.point_y));
            if (got.pressed !== want.pressed)
                report_mismatch("pressed", 32'(got.pressed), 32'(want.pressed));
            if (got.reply_id !== want.reply_id)
                report_mismatch("reply_id", got.reply_id, want.reply_id);
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
            beats_checked++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            screen_w   = SCREEN_RESET;
            screen_h   = SCREEN_RESET;
            g_active   = 1'b0;
            g_pressed  = 1'b0;
            g_from_x   = '0;
            g_from_y   = '0;
            g_to_x     = '0;
            g_to_y     = '0;
            g_len      = '0;
            g_start_ms = '0;
            g_id       = '0;
            pending_reports.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_SCREEN_WIDTH)
                    screen_w = cfg_wdata;
                else
                    screen_h = cfg_wdata;
            end
            // results at this edge belong to earlier beats: compare first
            if (m_valid && m_ready)
                compare_beat(m_data);
            if (s_valid && s_ready)
                advance_gesture(s_data);
        end
        outstanding <= pending_reports.size();
    end

endmodule

/* sim/tb_gesture_pointer_interpolator_top.sv */
// ----------------------------------------------------------------------------
// tb_gesture_pointer_interpolator_top: gesture interpolator testbench
// Drives directed corner cases, a result-side hold-off and random gesture
// traffic (well-formed taps and swipes followed by ticks, plus busy and
// malformed commands) over several screen sizes and handshake mixes.
// ----------------------------------------------------------------------------
module tb_gesture_pointer_interpolator_top;
    import gpi_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    gpi_in_t             s_data;
    logic                m_valid;
    logic                m_ready;
    gpi_out_t            m_data;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_BITS-1:0] cfg_wdata;

    int                  mismatches;
    int                  outstanding;
    int                  beats_checked;

    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  hold_left = 0;
    int                  beats_sent = 0;
    logic [31:0]         clock_ms;
    logic [CFG_BITS-1:0] screen_w_cur;
    logic [CFG_BITS-1:0] screen_h_cur;

    always #6 aclk = ~aclk;

    gesture_pointer_interpolator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gpi_gesture_monitor monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .beats_checked (beats_checked)
    );

    // result side: a pending hold-off wins over the random stall
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic gpi_in_t make_cmd(input logic [1:0] op, input logic [31:0] now,
                                         input logic [31:0] id, input int fx,
                                         input int fy, input int tx, input int ty,
                                         input int span);
        gpi_in_t c;
        c.opcode     = op;
        c.now_ms     = now;
        c.request_id = id;
        c.from_x     = 16'(fx);
        c.from_y     = 16'(fy);
        c.to_x       = 16'(tx);
        c.to_y       = 16'(ty);
        c.span_ms    = 16'(span);
        return c;
    endfunction

    function automatic gpi_in_t random_beat();
        return make_cmd(2'($urandom_range(3)), $urandom, $urandom, int'($urandom),
                        int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    endfunction

    function automatic gpi_in_t busy_command();
        gpi_in_t c;
        c        = random_beat();
        c.opcode = 2'($urandom_range(1, 3));
        return c;
    endfunction

    function automatic gpi_in_t tick_at(input logic [31:0] now);
        gpi_in_t c;
        c        = random_beat();
        c.opcode = OP_TICK;
        c.now_ms = now;
        return c;
    endfunction

    function automatic int idle_gap();
        int g;
        g = 0;
        while (g < 20 && $urandom_range(99) < send_idle_pct)
            g++;
        return g;
    endfunction

    // returns at the rising edge that accepts the beat, valid still high
    task automatic send_beat(input gpi_in_t it, input bit counts);
        int gap;
        begin
            gap = idle_gap();
            @(negedge aclk);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= it;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            if (counts)
                beats_sent++;
        end
    endtask

    // drop valid, drain every awaited beat, then cover a tick still in flight
    task automatic settle();
        begin
            @(negedge aclk);
            s_valid <= 1'b0;
            while (outstanding != 0)
                @(negedge aclk);
            repeat (40) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] val);
        begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(negedge aclk);
            cfg_we    <= 1'b0;
        end
    endtask

    task automatic set_mix(input int idle, input int stall);
        begin
            @(posedge aclk);
            send_idle_pct = idle;
            stall_pct     = stall;
        end
    endtask

    task automatic run_directed();
        begin
            send_beat(tick_at(32'd5), 1'b0);
            send_beat(make_cmd(OP_OTHER, 32'd6, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1'b1);
            send_beat(make_cmd(OP_TAP, 32'd1000, 32'h0, 0, 0, 5, 5, 5), 1'b1);
            send_beat(make_cmd(OP_TAP, 32'd1001, 32'h11, 1, 1, 0, 0, 0), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1002, 32'h22, 1, 1, 2, 2, 50), 1'b1);
            send_beat(make_cmd(OP_OTHER, 32'd1003, 32'h33, 0, 0, 0, 0, 0), 1'b1);
            send_beat(tick_at(32'd1050), 1'b1);
            send_beat(tick_at(32'd1100), 1'b1);
            // malformed points and durations
            send_beat(make_cmd(OP_SWIPE, 32'd1200, 32'h40, -1, 0, 10, 10, 100), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1201, 32'h41, 480, 0, 10, 10, 100), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1202, 32'h42, 0, 0, 10, 480, 100), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1203, 32'h43, -32768, 0, 1, 1, 100), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1204, 32'h44, 0, 32767, 1, 1, 100), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1205, 32'h45, 0, 0, 1, 1, 19), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1206, 32'h46, 0, 0, 1, 1, 2001), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1207, 32'h47, 0, 0, 1, 1, -32768), 1'b1);
            send_beat(make_cmd(OP_SWIPE, 32'd1208, 32'h48, 0, 0, 1, 1, 32767), 1'b1);
            // shortest swipe across the counter wrap
            send_beat(make_cmd(OP_SWIPE, 32'hFFFF_FFF0, 32'hA5A5_5A5A, 479, 0, 0, 479, 20),
                      1'b1);
            send_beat(tick_at(32'hFFFF_FFFA), 1'b1);
            send_beat(tick_at(32'h0000_0004), 1'b1);
            // longest swipe, ended by a tick whose now_ms lies behind its start
            send_beat(make_cmd(OP_SWIPE, 32'd5000, 32'h55, 0, 0, 479, 479, 2000), 1'b1);
            send_beat(tick_at(32'd5999), 1'b1);
            send_beat(tick_at(32'd4999), 1'b1);
            // tap ignores the end point and duration fields
            send_beat(make_cmd(OP_TAP, 32'd7000, 32'h66, 479, 479, -32768, 32767, -1), 1'b1);
            send_beat(tick_at(32'd7100), 1'b1);
            clock_ms = 32'd8000;
        end
    endtask

    // fill the result path while commands keep coming
    task automatic run_hold_off();
        begin
            send_beat(make_cmd(OP_SWIPE, clock_ms, $urandom, 10, 10, 200, 300, 500), 1'b1);
            hold_left = 600;
            repeat (40) send_beat(busy_command(), 1'b1);
            send_beat(tick_at(clock_ms + 32'd250), 1'b1);
            send_beat(tick_at(clock_ms + 32'd600), 1'b1);
            clock_ms = clock_ms + 32'd700;
        end
    endtask

    task automatic random_command(output gpi_in_t c, output int len, output bit good);
        int cw;
        int ch;
        begin
            cw = (screen_w_cur > 13'd4096) ? 4096 : int'(screen_w_cur);
            ch = (screen_h_cur > 13'd4096) ? 4096 : int'(screen_h_cur);
            len = ($urandom_range(3) == 0) ? $urandom_range(20, 2000)
                                           : $urandom_range(20, 120);
            c = make_cmd(OP_SWIPE, clock_ms, $urandom, $urandom_range(cw - 1),
                         $urandom_range(ch - 1), $urandom_range(cw - 1),
                         $urandom_range(ch - 1), len);
            good = 1'b1;
            if ($urandom_range(1) == 0) begin
                c.opcode  = OP_TAP;
                c.to_x    = 16'($urandom);
                c.to_y    = 16'($urandom);
                c.span_ms = 16'($urandom);
                len       = TAP_MS;
            end
            if ($urandom_range(9) == 0) begin
                // break one field of a swipe
                good      = 1'b0;
                c.opcode  = OP_SWIPE;
                c.to_x    = 16'($urandom_range(cw - 1));
                c.to_y    = 16'($urandom_range(ch - 1));
                c.span_ms = 16'(len);
                case ($urandom_range(5))
                    0: c.from_x  = 16'(-int'($urandom_range(1, 32768)));
                    1: c.from_y  = 16'($urandom_range(ch, 32767));
                    2: c.to_x    = 16'($urandom_range(cw, 32767));
                    3: c.to_y    = 16'(-int'($urandom_range(1, 32768)));
                    4: c.span_ms = 16'(int'($urandom_range(32787)) - 32768);
                    default: c.span_ms = 16'($urandom_range(2001, 32767));
                endcase
            end
        end
    endtask

    task automatic play_gesture();
        gpi_in_t     c;
        int          len;
        int          spent;
        int          step;
        bit          good;
        logic [31:0] t0;
        begin
            random_command(c, len, good);
            send_beat(c, 1'b1);
            if (!good)
                return;
            t0    = clock_ms;
            spent = 0;
            while (spent < len) begin
                if ($urandom_range(9) == 0)
                    send_beat(busy_command(), 1'b1);
                if ($urandom_range(24) == 0) begin
                    clock_ms = t0 - $urandom_range(1, 5000);
                    spent    = len;
                end else begin
                    step     = $urandom_range(1, len / 3 + 1);
                    clock_ms = clock_ms + step;
                    spent    = spent + step;
                end
                send_beat(tick_at(clock_ms), 1'b1);
            end
            if ($urandom_range(4) == 0)
                send_beat(tick_at(clock_ms + $urandom_range(1, 50)), 1'b0);
        end
    endtask

    task automatic play_phase(input int beats);
        gpi_in_t b;
        int      goal;
        begin
            goal = beats_sent + beats;
            if ($urandom_range(2) == 0)
                clock_ms = 32'hFFFF_F000 + $urandom_range(4000);
            else
                clock_ms = $urandom;
            while (beats_sent < goal) begin
                if ($urandom_range(99) < 80) begin
                    play_gesture();
                end else begin
                    b = random_beat();
                    send_beat(b, b.opcode != OP_TICK);
                end
            end
        end
    endtask

    initial begin
        logic [CFG_BITS-1:0] widths[8];
        logic [CFG_BITS-1:0] heights[8];
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_SCREEN_WIDTH;
        cfg_wdata    = '0;
        clock_ms     = '0;
        screen_w_cur = SCREEN_RESET;
        screen_h_cur = SCREEN_RESET;
        widths  = '{13'd480, 13'd4096, 13'd1, 13'd640, 13'd4096, 13'd1, 13'd0, 13'd480};
        heights = '{13'd480, 13'd4096, 13'd1, 13'd360, 13'd1, 13'd4096, 13'd0, 13'd480};
        widths[6]  = 13'($urandom_range(1, 4096));
        heights[6] = 13'($urandom_range(1, 4096));
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_hold_off();
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                write_reg(REG_SCREEN_WIDTH, widths[ph]);
                write_reg(REG_SCREEN_HEIGHT, heights[ph]);
                screen_w_cur = widths[ph];
                screen_h_cur = heights[ph];
            end
            case (ph % 4)
                0: set_mix(0, 0);
                1: set_mix(62, 0);
                2: set_mix(0, 62);
                default: set_mix(28, 28);
            endcase
            play_phase(210);
            settle();
        end

        $display("Sent %0d command and tick beats over 8 screen sizes, four handshake mixes",
                 beats_sent);
        $display("and a result-side hold-off; %0d result beats compared, %0d mismatches",
                 beats_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS gesture_pointer_interpolator_top");
        else
            $display("FAIL gesture_pointer_interpolator_top");
        $finish;
    end

    initial begin
        #48_000_000;
        $display("Timed out with %0d result beats still awaited", outstanding);
        $display("FAIL gesture_pointer_interpolator_top");
        $finish;
    end

endmodule

/* gesture_pointer_interpolator_top.f */
src/gpi_pkg.sv
src/gpi_lane.sv
src/gpi_outq.sv
src/gesture_pointer_interpolator_top.sv
sim/gpi_gesture_monitor.sv
sim/tb_gesture_pointer_interpolator_top.sv
